// ===== design/assert_macros.svh =====
// Assertion macros shared by the top-N insertion tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/tnit_pkg.sv =====
// Package with the shared types and constants of the top-N insertion tracker.
`default_nettype none

package tnit_pkg;

  localparam int unsigned TOP_N_DEF = 10;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned SEC_W     = 32;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned SLOT_W    = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_OFFER = 2'd0,
    REQ_DUMP  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    RESP_OFFER = 2'd0,
    RESP_ENTRY = 2'd1,
    RESP_CLEAR = 2'd2
  } resp_e;

  typedef struct packed {
    logic latch;
    logic compare;
    logic insert;
    logic dump_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_last;
  } status_t;

endpackage

`default_nettype wire

// ===== design/top_n_insertion_tracker.sv =====
// Top level of the top-N insertion tracker.
//
// Keeps the TOP_N largest offered values in descending order, earliest first among equal
// values. A request is taken only while the block is idle. An offer is latched when it is
// taken, then compared in a registered step against all stored entries in parallel, and
// then the list is shifted and the response loaded, so no new request is taken until the
// offer's response is loaded. A dump of N entries returns them in order (one empty entry
// when the list is empty), as the list rotates through its head entry and one entry leaves
// per cycle while the output is not stalled. Every response waits in one output register,
// and a stalled output holds the block in its current step.
`default_nettype none

module top_n_insertion_tracker #(
  parameter int unsigned TOP_N = tnit_pkg::TOP_N_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tnit_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [tnit_pkg::VALUE_W-1:0]  offer_value_i,
  input  wire logic [tnit_pkg::SEC_W-1:0]    offer_secondary_i,
  input  wire logic [tnit_pkg::TAG_W-1:0]    offer_tag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         resp_kind_o,
  output logic                               accepted_o,
  output logic [tnit_pkg::SLOT_W-1:0]        slot_o,
  output logic                               entry_valid_o,
  output logic [tnit_pkg::VALUE_W-1:0]       entry_value_o,
  output logic [tnit_pkg::SEC_W-1:0]         entry_secondary_o,
  output logic [tnit_pkg::TAG_W-1:0]         entry_tag_o,
  output logic [tnit_pkg::SLOT_W-1:0]        fill_level_o,
  output logic                               last_o
);

  tnit_pkg::cmd_t    cmd;
  tnit_pkg::status_t status;

  tnit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tnit_dpath #(
    .TOP_N (TOP_N)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .offer_value_i     (offer_value_i),
    .offer_secondary_i (offer_secondary_i),
    .offer_tag_i       (offer_tag_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .resp_kind_o       (resp_kind_o),
    .accepted_o        (accepted_o),
    .slot_o            (slot_o),
    .entry_valid_o     (entry_valid_o),
    .entry_value_o     (entry_value_o),
    .entry_secondary_o (entry_secondary_o),
    .entry_tag_o       (entry_tag_o),
    .fill_level_o      (fill_level_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

// ===== design/tnit_ctrl.sv =====
// Controller state machine of the top-N insertion tracker.
`default_nettype none
`include "assert_macros.svh"

module tnit_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tnit_pkg::REQ_W-1:0]  req_type_i,
  input  wire tnit_pkg::status_t           status_i,
  output tnit_pkg::cmd_t                   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_INS  = 5'b00100,
    S_DUMP = 5'b01000,
    S_CLR  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          unique case (req_type_i)
            tnit_pkg::REQ_OFFER: state_d = S_CMP;
            tnit_pkg::REQ_DUMP:  state_d = S_DUMP;
            tnit_pkg::REQ_CLEAR: state_d = S_CLR;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = S_INS;
      end
      S_INS: begin
        if (status_i.out_free) begin
          cmd_o.insert = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (status_i.out_free) begin
          cmd_o.dump_step = 1'b1;
          if (status_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_CLR: begin
        if (status_i.out_free) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CLK(a_cmp_then_ins, state_q == S_CMP |=> state_q == S_INS, "compare not followed by insert")
  `ASSERT_CLK(a_one_cmd, $countones(cmd_o) <= 1, "more than one datapath command at once")
  `ASSERT_CLK(a_state_onehot, $onehot(state_q), "state register not one-hot")

endmodule

`default_nettype wire

// ===== design/tnit_dpath.sv =====
// Datapath of the top-N insertion tracker: entry list, compare, shift and result register.
`default_nettype none
`include "assert_macros.svh"

module tnit_dpath #(
  parameter int unsigned TOP_N = tnit_pkg::TOP_N_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tnit_pkg::cmd_t                cmd_i,
  output tnit_pkg::status_t                  status_o,
  input  wire logic [tnit_pkg::VALUE_W-1:0]  offer_value_i,
  input  wire logic [tnit_pkg::SEC_W-1:0]    offer_secondary_i,
  input  wire logic [tnit_pkg::TAG_W-1:0]    offer_tag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         resp_kind_o,
  output logic                               accepted_o,
  output logic [tnit_pkg::SLOT_W-1:0]        slot_o,
  output logic                               entry_valid_o,
  output logic [tnit_pkg::VALUE_W-1:0]       entry_value_o,
  output logic [tnit_pkg::SEC_W-1:0]         entry_secondary_o,
  output logic [tnit_pkg::TAG_W-1:0]         entry_tag_o,
  output logic [tnit_pkg::SLOT_W-1:0]        fill_level_o,
  output logic                               last_o
);

  localparam int unsigned CW = $clog2(TOP_N + 1);

  logic [tnit_pkg::VALUE_W-1:0] val_q [TOP_N];
  logic [tnit_pkg::VALUE_W-1:0] val_d [TOP_N];
  logic [tnit_pkg::SEC_W-1:0]   sec_q [TOP_N];
  logic [tnit_pkg::SEC_W-1:0]   sec_d [TOP_N];
  logic [tnit_pkg::TAG_W-1:0]   tag_q [TOP_N];
  logic [tnit_pkg::TAG_W-1:0]   tag_d [TOP_N];

  logic [tnit_pkg::VALUE_W-1:0] req_val_q;
  logic [tnit_pkg::SEC_W-1:0]   req_sec_q;
  logic [tnit_pkg::TAG_W-1:0]   req_tag_q;

  logic [CW-1:0]    cnt_q, cnt_d, cnt_m1;
  logic [CW-1:0]    dump_q;
  logic [TOP_N-1:0] ge_d, ge_q, ins_edge;
  logic [CW-1:0]    pos;
  logic             full_ge, dump_empty, dump_last, load;

  tnit_pkg::resp_e              resp_kind_q;
  logic                         out_valid_q, accepted_q, entry_valid_q, last_q;
  logic [tnit_pkg::SLOT_W-1:0]  slot_q, fill_q;
  logic [tnit_pkg::VALUE_W-1:0] entry_value_q;
  logic [tnit_pkg::SEC_W-1:0]   entry_secondary_q;
  logic [tnit_pkg::TAG_W-1:0]   entry_tag_q;

  assign cnt_m1     = cnt_q - CW'(1);
  assign dump_empty = (cnt_q == '0);
  assign dump_last  = dump_empty || (dump_q == cnt_m1);
  assign full_ge    = &ge_q;
  assign load       = cmd_i.insert || cmd_i.dump_step || cmd_i.clear;

  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.dump_last = dump_last;

  for (genvar g = 0; g < TOP_N; g++) begin : g_entry
    assign ge_d[g] = (CW'(g) < cnt_q) && (val_q[g] >= req_val_q);

    if (g == 0) begin : g_head
      assign ins_edge[g] = !ge_q[g];
    end else begin : g_body
      assign ins_edge[g] = !ge_q[g] && ge_q[g-1];
    end

    always_comb begin
      val_d[g] = val_q[g];
      sec_d[g] = sec_q[g];
      tag_d[g] = tag_q[g];
      if (cmd_i.insert && !ge_q[g]) begin
        if (ins_edge[g]) begin
          val_d[g] = req_val_q;
          sec_d[g] = req_sec_q;
          tag_d[g] = req_tag_q;
        end else begin
          if (g > 0) begin
            val_d[g] = val_q[(g > 0) ? g - 1 : 0];
            sec_d[g] = sec_q[(g > 0) ? g - 1 : 0];
            tag_d[g] = tag_q[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (cmd_i.dump_step && !dump_empty) begin
        if (CW'(g) == cnt_m1) begin
          val_d[g] = val_q[0];
          sec_d[g] = sec_q[0];
          tag_d[g] = tag_q[0];
        end else if (CW'(g) < cnt_m1) begin
          val_d[g] = val_q[(g + 1 < TOP_N) ? g + 1 : g];
          sec_d[g] = sec_q[(g + 1 < TOP_N) ? g + 1 : g];
          tag_d[g] = tag_q[(g + 1 < TOP_N) ? g + 1 : g];
        end
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < TOP_N; i++) begin
      if (ins_edge[i]) begin
        pos = pos | CW'(i);
      end
    end
    if (full_ge) begin
      pos = CW'(TOP_N);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.insert && !full_ge && (cnt_q < CW'(TOP_N))) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.clear) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TOP_N; i++) begin
      val_q[i] <= val_d[i];
      sec_q[i] <= sec_d[i];
      tag_q[i] <= tag_d[i];
    end
    if (cmd_i.latch) begin
      req_val_q <= offer_value_i;
      req_sec_q <= offer_secondary_i;
      req_tag_q <= offer_tag_i;
    end
    if (cmd_i.compare) begin
      ge_q <= ge_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dump_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.latch) begin
        dump_q <= '0;
      end else if (cmd_i.dump_step) begin
        dump_q <= dump_q + CW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      accepted_q        <= 1'b0;
      slot_q            <= '0;
      entry_valid_q     <= 1'b0;
      entry_value_q     <= '0;
      entry_secondary_q <= '0;
      entry_tag_q       <= '0;
      fill_q            <= tnit_pkg::SLOT_W'(cnt_d);
      last_q            <= 1'b1;
      if (cmd_i.insert) begin
        resp_kind_q <= tnit_pkg::RESP_OFFER;
        accepted_q  <= !full_ge;
        slot_q      <= tnit_pkg::SLOT_W'(pos);
      end else if (cmd_i.dump_step) begin
        resp_kind_q <= tnit_pkg::RESP_ENTRY;
        slot_q      <= tnit_pkg::SLOT_W'(dump_q);
        last_q      <= dump_last;
        if (!dump_empty) begin
          entry_valid_q     <= 1'b1;
          entry_value_q     <= val_q[0];
          entry_secondary_q <= sec_q[0];
          entry_tag_q       <= tag_q[0];
        end
      end else begin
        resp_kind_q <= tnit_pkg::RESP_CLEAR;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign resp_kind_o       = resp_kind_q;
  assign accepted_o        = accepted_q;
  assign slot_o            = slot_q;
  assign entry_valid_o     = entry_valid_q;
  assign entry_value_o     = entry_value_q;
  assign entry_secondary_o = entry_secondary_q;
  assign entry_tag_o       = entry_tag_q;
  assign fill_level_o      = fill_q;
  assign last_o            = last_q;

  `ASSERT_CLK(a_cnt_bound, cnt_q <= CW'(TOP_N), "fill count above list size")
  `ASSERT_NEVER(a_load_busy, load && out_valid_q && out_stall_i, "result register overwritten")
  `ASSERT_CLK(a_dump_keeps_cnt, cmd_i.dump_step |=> $stable(cnt_q), "dump changed fill count")

endmodule

`default_nettype wire

// ===== bench/top_n_insertion_tracker_tb.sv =====
// Self-checking testbench for the top-N insertion tracker, with directed, random and backpressure tests.
`timescale 1ns / 1ps

module top_n_insertion_tracker_tb;

  localparam int unsigned TOP_N = tnit_pkg::TOP_N_DEF;
  localparam logic [tnit_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    tnit_pkg::resp_e                kind;
    logic                           accepted;
    logic [tnit_pkg::SLOT_W-1:0]    slot;
    logic                           entry_valid;
    logic [tnit_pkg::VALUE_W-1:0]   value;
    logic [tnit_pkg::SEC_W-1:0]     secondary;
    logic [tnit_pkg::TAG_W-1:0]     tag;
    logic [tnit_pkg::SLOT_W-1:0]    fill;
    logic                           last;
  } tracker_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [tnit_pkg::REQ_W-1:0] req_type_i = '0;
  logic [tnit_pkg::VALUE_W-1:0] offer_value_i = '0;
  logic [tnit_pkg::SEC_W-1:0] offer_secondary_i = '0;
  logic [tnit_pkg::TAG_W-1:0] offer_tag_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] resp_kind_o;
  logic accepted_o;
  logic [tnit_pkg::SLOT_W-1:0] slot_o;
  logic entry_valid_o;
  logic [tnit_pkg::VALUE_W-1:0] entry_value_o;
  logic [tnit_pkg::SEC_W-1:0] entry_secondary_o;
  logic [tnit_pkg::TAG_W-1:0] entry_tag_o;
  logic [tnit_pkg::SLOT_W-1:0] fill_level_o;
  logic last_o;

  logic [tnit_pkg::VALUE_W-1:0] ranked_value [TOP_N];
  logic [tnit_pkg::SEC_W-1:0] ranked_secondary [TOP_N];
  logic [tnit_pkg::TAG_W-1:0] ranked_tag [TOP_N];
  int held_count = 0;
  tracker_resp_t result_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int results_seen = 0;
  int offers = 0;
  int drops = 0;
  int dumps = 0;
  int clears = 0;
  int ignored = 0;

  top_n_insertion_tracker #(.TOP_N(TOP_N)) dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic tracker_resp_t make_resp(input tnit_pkg::resp_e kind, input logic acc,
                                              input int slot, input logic ev,
                                              input logic [tnit_pkg::VALUE_W-1:0] value,
                                              input logic [tnit_pkg::SEC_W-1:0] secondary,
                                              input logic [tnit_pkg::TAG_W-1:0] tag,
                                              input logic last);
    tracker_resp_t r;
    r.kind = kind;
    r.accepted = acc;
    r.slot = slot[tnit_pkg::SLOT_W-1:0];
    r.entry_valid = ev;
    r.value = value;
    r.secondary = secondary;
    r.tag = tag;
    r.fill = held_count[tnit_pkg::SLOT_W-1:0];
    r.last = last;
    return r;
  endfunction

  task automatic predict_request(input logic [tnit_pkg::REQ_W-1:0] req,
                                 input logic [tnit_pkg::VALUE_W-1:0] value,
                                 input logic [tnit_pkg::SEC_W-1:0] secondary,
                                 input logic [tnit_pkg::TAG_W-1:0] tag);
    int pos;
    int i;
    if (req == tnit_pkg::REQ_OFFER) begin
      offers++;
      pos = held_count;
      while (pos > 0 && ranked_value[pos-1] < value) pos--;
      if (pos >= TOP_N) begin
        drops++;
        result_q.push_back(make_resp(tnit_pkg::RESP_OFFER, 1'b0, TOP_N, 1'b0, '0, '0, '0,
                                     1'b1));
      end else begin
        if (held_count < TOP_N) held_count++;
        for (i = held_count - 1; i > pos; i--) begin
          ranked_value[i] = ranked_value[i-1];
          ranked_secondary[i] = ranked_secondary[i-1];
          ranked_tag[i] = ranked_tag[i-1];
        end
        ranked_value[pos] = value;
        ranked_secondary[pos] = secondary;
        ranked_tag[pos] = tag;
        result_q.push_back(make_resp(tnit_pkg::RESP_OFFER, 1'b1, pos, 1'b0, '0, '0, '0, 1'b1));
      end
    end else if (req == tnit_pkg::REQ_DUMP) begin
      dumps++;
      if (held_count == 0) begin
        result_q.push_back(make_resp(tnit_pkg::RESP_ENTRY, 1'b0, 0, 1'b0, '0, '0, '0, 1'b1));
      end else begin
        for (i = 0; i < held_count; i++) begin
          result_q.push_back(make_resp(tnit_pkg::RESP_ENTRY, 1'b0, i, 1'b1, ranked_value[i],
                                       ranked_secondary[i], ranked_tag[i],
                                       i + 1 == held_count));
        end
      end
    end else if (req == tnit_pkg::REQ_CLEAR) begin
      clears++;
      held_count = 0;
      result_q.push_back(make_resp(tnit_pkg::RESP_CLEAR, 1'b0, 0, 1'b0, '0, '0, '0, 1'b1));
    end else begin
      ignored++;
    end
  endtask

  task automatic send_request(input logic [tnit_pkg::REQ_W-1:0] req,
                              input logic [tnit_pkg::VALUE_W-1:0] value,
                              input logic [tnit_pkg::SEC_W-1:0] secondary,
                              input logic [tnit_pkg::TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    offer_value_i <= value;
    offer_secondary_i <= secondary;
    offer_tag_i <= tag;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(req, value, secondary, tag);
    @(negedge clk_i);
  endtask

  function automatic logic [tnit_pkg::VALUE_W-1:0] random_value();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom;
      2: return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom_range(1000);
    endcase
  endfunction

  task automatic test_directed_cases();
    send_idle_pct = 10;
    recv_stall_pct <= 30;
    send_request(tnit_pkg::REQ_DUMP, '0, '0, '0);
    send_request(REQ_UNUSED, '1, '1, '1);
    send_request(tnit_pkg::REQ_OFFER, 32'd0, 32'd0, 16'd0);
    send_request(tnit_pkg::REQ_OFFER, '1, '1, '1);
    send_request(tnit_pkg::REQ_OFFER, 32'd100, 32'd1, 16'd1);
    send_request(tnit_pkg::REQ_OFFER, 32'd100, 32'd2, 16'd2);
    send_request(tnit_pkg::REQ_OFFER, 32'd50, 32'd3, 16'd3);
    send_request(tnit_pkg::REQ_OFFER, 32'd200, 32'd4, 16'd4);
    send_request(tnit_pkg::REQ_OFFER, 32'd7, 32'd5, 16'd5);
    send_request(tnit_pkg::REQ_OFFER, 32'd100, 32'd6, 16'd6);
    send_request(tnit_pkg::REQ_OFFER, 32'd0, 32'd7, 16'd7);
    send_request(tnit_pkg::REQ_OFFER, 32'd0, 32'd8, 16'd8);
    send_request(tnit_pkg::REQ_OFFER, 32'd0, 32'd9, 16'd9);
    send_request(tnit_pkg::REQ_OFFER, 32'd1, 32'hAAAA_5555, 16'h5AA5);
    send_request(tnit_pkg::REQ_OFFER, '1, 32'h5555_AAAA, 16'hA55A);
    send_request(tnit_pkg::REQ_DUMP, '1, '1, '1);
    send_request(tnit_pkg::REQ_CLEAR, '1, '0, '1);
    send_request(tnit_pkg::REQ_DUMP, '0, '0, '0);
    send_request(tnit_pkg::REQ_OFFER, 32'd5, 32'd10, 16'd10);
  endtask

  task automatic run_random_phase(input int requests, input int send_pct, input int recv_pct);
    int sent;
    int pick;
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    sent = 0;
    while (sent < requests) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_request(tnit_pkg::REQ_OFFER, random_value(), $urandom,
                     16'($urandom_range(16'hFFFF)));
        sent++;
      end else if (pick < 91) begin
        send_request(tnit_pkg::REQ_DUMP, $urandom, $urandom, 16'($urandom_range(16'hFFFF)));
        sent++;
      end else if (pick < 96) begin
        send_request(tnit_pkg::REQ_CLEAR, $urandom, $urandom, 16'($urandom_range(16'hFFFF)));
        sent++;
      end else begin
        send_request(REQ_UNUSED, $urandom, $urandom, 16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  task automatic test_random_mixed_idling();
    run_random_phase(90, 25, 57);
    run_random_phase(90, 57, 25);
    run_random_phase(90, 0, 0);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (14) send_request(tnit_pkg::REQ_OFFER, random_value(), $urandom,
                             16'($urandom_range(16'hFFFF)));
    send_request(tnit_pkg::REQ_DUMP, '0, '0, '0);
  endtask

  always @(negedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    tracker_resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got kind %0d slot %0d", $time, resp_kind_o,
                 slot_o);
      end else begin
        want = result_q.pop_front();
        results_seen++;
        check_field("resp_kind", want.kind, resp_kind_o);
        check_field("accepted", want.accepted, accepted_o);
        check_field("slot", want.slot, slot_o);
        check_field("entry_valid", want.entry_valid, entry_valid_o);
        check_field("entry_value", want.value, entry_value_o);
        check_field("entry_secondary", want.secondary, entry_secondary_o);
        check_field("entry_tag", want.tag, entry_tag_o);
        check_field("fill_level", want.fill, fill_level_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles with %0d results pending", $time, CYCLE_LIMIT,
               result_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_random_mixed_idling();
    test_output_backpressure();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d offers (%0d dropped), %0d dumps, %0d clears, %0d unused codes.",
             offers, drops, dumps, clears, ignored);
    $display("Checked %0d results under mixed idling and a long output hold.", results_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/tnit_pkg.sv
design/tnit_ctrl.sv
design/tnit_dpath.sv
design/top_n_insertion_tracker.sv
bench/top_n_insertion_tracker_tb.sv
